// File: rtl/esbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esbd_pkg
// Types, constants, microcode program and helpers for the epoch seconds to
// BCD calendar date converter.
// ----------------------------------------------------------------------------
package esbd_pkg;

  localparam int unsigned SecsWidth = 32;

  localparam logic [SecsWidth-1:0] SecsLeapYear   = 32'd31622400;
  localparam logic [SecsWidth-1:0] SecsCommonYear = 32'd31536000;
  localparam logic [SecsWidth-1:0] SecsDay        = 32'd86400;
  localparam logic [SecsWidth-1:0] SecsHour       = 32'd3600;
  localparam logic [SecsWidth-1:0] SecsMinute     = 32'd60;
  localparam logic [SecsWidth-1:0] EpochEndSecs   = 32'd4102444800;

  // Year offset from 1970 at which the century turns to 20xx.
  localparam logic [7:0] CenturyTurnOffset = 8'd30;

  typedef enum logic [1:0] {
    OP_TEST_RANGE = 2'd0,
    OP_TAKE       = 2'd1,
    OP_EMIT       = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    SEL_YEAR   = 3'd0,
    SEL_MONTH  = 3'd1,
    SEL_DAY    = 3'd2,
    SEL_HOUR   = 3'd3,
    SEL_MINUTE = 3'd4
  } sel_e;

  localparam int unsigned ProgLen = 7;
  localparam int unsigned PcWidth = $clog2(ProgLen);

  typedef logic [PcWidth-1:0] pc_t;

  typedef struct packed {
    op_e  op;
    sel_e sel;
    pc_t  target;
  } ucode_t;

  localparam pc_t PcFirst = pc_t'(0);
  localparam pc_t PcEmit  = pc_t'(6);

  // Microcode: TEST jumps to target when out of range; TAKE jumps to target
  // (itself) while the unit still fits in the remainder; EMIT waits for the
  // output register, then ends the transaction.
  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    unique case (pc)
      pc_t'(0): w = '{op: OP_TEST_RANGE, sel: SEL_YEAR,   target: PcEmit};
      pc_t'(1): w = '{op: OP_TAKE,       sel: SEL_YEAR,   target: pc_t'(1)};
      pc_t'(2): w = '{op: OP_TAKE,       sel: SEL_MONTH,  target: pc_t'(2)};
      pc_t'(3): w = '{op: OP_TAKE,       sel: SEL_DAY,    target: pc_t'(3)};
      pc_t'(4): w = '{op: OP_TAKE,       sel: SEL_HOUR,   target: pc_t'(4)};
      pc_t'(5): w = '{op: OP_TAKE,       sel: SEL_MINUTE, target: pc_t'(5)};
      default:  w = '{op: OP_EMIT,       sel: SEL_YEAR,   target: PcFirst};
    endcase
    return w;
  endfunction

  // Seconds in month m (0 = January).
  function automatic logic [SecsWidth-1:0] month_secs(input logic [3:0] m,
                                                      input logic leap);
    logic [SecsWidth-1:0] s;
    unique case (m)
      4'd1:                      s = leap ? 32'd2505600 : 32'd2419200;
      4'd3, 4'd5, 4'd8, 4'd10:   s = 32'd2592000;
      default:                   s = 32'd2678400;
    endcase
    return s;
  endfunction

  // Two BCD digits of a value below 100.
  function automatic logic [7:0] to_bcd2(input logic [6:0] v);
    logic [3:0] tens;
    logic [6:0] ones;
    tens = 4'd0;
    for (int i = 1; i < 10; i++) begin
      if (v >= 7'(10 * i)) tens = 4'(i);
    end
    ones = v - 7'(tens * 10);
    return {tens, ones[3:0]};
  endfunction

endpackage

// File: rtl/esbd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esbd_in_if / esbd_out_if
// Valid/ready channels carrying input seconds and BCD date results.
// ----------------------------------------------------------------------------
interface esbd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] seconds_since_epoch;

  modport source (output valid, output seconds_since_epoch, input ready);
  modport sink   (input valid, input seconds_since_epoch, output ready);
endinterface

interface esbd_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] year_bcd;
  logic [4:0]  month_bcd;
  logic [5:0]  day_bcd;
  logic [5:0]  hour_bcd;
  logic [6:0]  minute_bcd;
  logic [6:0]  second_bcd;
  logic        out_of_range;

  modport source (output valid, output year_bcd, output month_bcd, output day_bcd,
                  output hour_bcd, output minute_bcd, output second_bcd,
                  output out_of_range, input ready);
  modport sink   (input valid, input year_bcd, input month_bcd, input day_bcd,
                  input hour_bcd, input minute_bcd, input second_bcd,
                  input out_of_range, output ready);
endinterface

// File: rtl/epoch_seconds_to_bcd_date_unit.sv
// An out-of-range input skips from the range test straight to the emit step.
// Throughput: one transaction at a time; the subtract loop of the microcode
// sequencer takes one year, month, day, hour or minute per cycle.
// The next transaction is accepted while a result waits in the output register.
// Reset clears the sequencer and the output valid; no memory to clear.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_bcd_date_unit
// Converts seconds since 1970-01-01 to packed BCD date and time with a
// microcoded subtract-and-count sequencer.
// ----------------------------------------------------------------------------
module epoch_seconds_to_bcd_date_unit
  import esbd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  esbd_in_if.sink    in_i,
  esbd_out_if.source out_o
);

  logic                 busy_q, busy_d;
  pc_t                  pc_q, pc_d;
  logic                 oor_q;
  logic [SecsWidth-1:0] rem_q, rem_d;
  logic [7:0]           year_q, year_d;
  logic [3:0]           month_q, month_d;
  logic [4:0]           day_q, day_d;
  logic [4:0]           hour_q, hour_d;
  logic [5:0]           minute_q, minute_d;

  logic        out_valid_q, out_valid_d;
  logic [13:0] out_year_q;
  logic [4:0]  out_month_q;
  logic [5:0]  out_day_q;
  logic [5:0]  out_hour_q;
  logic [6:0]  out_minute_q;
  logic [6:0]  out_second_q;
  logic        out_oor_q;

  ucode_t               uw;
  logic                 leap;
  logic [SecsWidth-1:0] unit_len;
  logic                 fits;
  logic                 in_fire;
  logic                 emit;
  logic [7:0]           year_lo;
  logic [7:0]           year_hi_bcd;
  logic [7:0]           month_bcd, day_bcd, hour_bcd, minute_bcd, second_bcd;

  assign uw      = ucode_rom(pc_q);
  assign leap    = (year_q[1:0] == 2'd2);
  assign in_fire = in_i.valid && in_i.ready;
  assign in_i.ready = !busy_q;

  always_comb begin
    unique case (uw.sel)
      SEL_YEAR:   unit_len = leap ? SecsLeapYear : SecsCommonYear;
      SEL_MONTH:  unit_len = month_secs(month_q, leap);
      SEL_DAY:    unit_len = SecsDay;
      SEL_HOUR:   unit_len = SecsHour;
      SEL_MINUTE: unit_len = SecsMinute;
      default:    unit_len = SecsDay;
    endcase
  end

  assign fits = (rem_q >= unit_len);
  assign emit = busy_q && (uw.op == OP_EMIT) && (!out_valid_q || out_o.ready);

  always_comb begin
    busy_d   = busy_q;
    pc_d     = pc_q;
    rem_d    = rem_q;
    year_d   = year_q;
    month_d  = month_q;
    day_d    = day_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    if (!busy_q) begin
      if (in_fire) begin
        busy_d   = 1'b1;
        pc_d     = PcFirst;
        rem_d    = in_i.seconds_since_epoch;
        year_d   = '0;
        month_d  = '0;
        day_d    = '0;
        hour_d   = '0;
        minute_d = '0;
      end
    end else begin
      unique case (uw.op)
        OP_TEST_RANGE: pc_d = oor_q ? uw.target : pc_q + pc_t'(1);
        OP_TAKE: begin
          if (fits) begin
            pc_d  = uw.target;
            rem_d = rem_q - unit_len;
            unique case (uw.sel)
              SEL_YEAR:   year_d   = year_q + 8'd1;
              SEL_MONTH:  month_d  = month_q + 4'd1;
              SEL_DAY:    day_d    = day_q + 5'd1;
              SEL_HOUR:   hour_d   = hour_q + 5'd1;
              SEL_MINUTE: minute_d = minute_q + 6'd1;
              default:    year_d   = year_q;
            endcase
          end else begin
            pc_d = pc_q + pc_t'(1);
          end
        end
        OP_EMIT: begin
          if (emit) begin
            busy_d = 1'b0;
            pc_d   = uw.target;
          end
        end
        default: pc_d = PcFirst;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= PcFirst;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) oor_q <= (in_i.seconds_since_epoch >= EpochEndSecs);
    rem_q    <= rem_d;
    year_q   <= year_d;
    month_q  <= month_d;
    day_q    <= day_d;
    hour_q   <= hour_d;
    minute_q <= minute_d;
  end

  // BCD formatting of the counters
  assign year_lo     = (year_q >= CenturyTurnOffset) ? year_q - CenturyTurnOffset
                                                     : year_q + 8'd70;
  assign year_hi_bcd = (year_q >= CenturyTurnOffset) ? 8'h20 : 8'h19;
  assign month_bcd   = to_bcd2(7'(month_q) + 7'd1);
  assign day_bcd     = to_bcd2(7'(day_q) + 7'd1);
  assign hour_bcd    = to_bcd2(7'(hour_q));
  assign minute_bcd  = to_bcd2(7'(minute_q));
  assign second_bcd  = to_bcd2(rem_q[6:0]);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) out_valid_d = 1'b0;
    if (emit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_oor_q <= oor_q;
      if (oor_q) begin
        out_year_q   <= '0;
        out_month_q  <= '0;
        out_day_q    <= '0;
        out_hour_q   <= '0;
        out_minute_q <= '0;
        out_second_q <= '0;
      end else begin
        out_year_q   <= {year_hi_bcd[5:0], to_bcd2(year_lo[6:0])};
        out_month_q  <= month_bcd[4:0];
        out_day_q    <= day_bcd[5:0];
        out_hour_q   <= hour_bcd[5:0];
        out_minute_q <= minute_bcd[6:0];
        out_second_q <= second_bcd[6:0];
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.year_bcd     = out_year_q;
  assign out_o.month_bcd    = out_month_q;
  assign out_o.day_bcd      = out_day_q;
  assign out_o.hour_bcd     = out_hour_q;
  assign out_o.minute_bcd   = out_minute_q;
  assign out_o.second_bcd   = out_second_q;
  assign out_o.out_of_range = out_oor_q;

`ifndef NO_ASSERTIONS
  a_rise_after_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(busy_q))
    else $error("result raised without a transaction in flight");

  a_oor_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_oor_q) |-> (out_year_q == '0 && out_month_q == '0 &&
      out_day_q == '0 && out_hour_q == '0 && out_minute_q == '0 &&
      out_second_q == '0))
    else $error("out-of-range result carries nonzero fields");

  a_pc_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pc_q <= PcEmit))
    else $error("sequencer ran past the program");

  a_month_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !oor_q && pc_q > pc_t'(1)) |-> (month_q <= 4'd11))
    else $error("month counter overran");

  a_done_frees : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (!busy_q && out_valid_q))
    else $error("emit step did not hand off the result");
`endif

endmodule

// File: tb/epoch_seconds_to_bcd_date_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_bcd_date_unit_test
// Self-checking bench for the epoch seconds to BCD calendar converter. A table
// of calendar edges runs first, then random seconds weighted toward month and
// year boundaries and past-2099 values. Each result is checked against a
// typed-in expectation or a behavioral calendar model, with random idle gaps
// on the input and random backpressure on the output.
// ----------------------------------------------------------------------------
module epoch_seconds_to_bcd_date_unit_test
  import esbd_pkg::*;
;

  localparam int unsigned HoldCycles  = 800;
  localparam int unsigned DrainCycles = 300;
  localparam int unsigned CycleLimit  = 2000000;

  typedef struct packed {
    logic [13:0] year_bcd;
    logic [4:0]  month_bcd;
    logic [5:0]  day_bcd;
    logic [5:0]  hour_bcd;
    logic [6:0]  minute_bcd;
    logic [6:0]  second_bcd;
    logic        out_of_range;
  } date_t;

  typedef struct packed {
    logic [31:0] secs;
    logic        fixed;
    date_t       want;
  } row_t;

  typedef struct packed {
    logic  fixed;
    date_t want;
  } pending_t;

  localparam date_t PastRange = '{14'h0, 5'h0, 6'h0, 6'h0, 7'h0, 7'h0, 1'b1};

  // fixed = 1: expected date typed in; otherwise taken from the calendar model
  localparam int unsigned NumRows = 24;
  localparam row_t DirectedRows [NumRows] = '{
    '{32'd0,          1'b1, '{14'h1970, 5'h01, 6'h01, 6'h00, 7'h00, 7'h00, 1'b0}},
    '{32'd59,         1'b0, '0},
    '{32'd60,         1'b0, '0},
    '{32'd3599,       1'b0, '0},
    '{32'd3600,       1'b0, '0},
    '{32'd86399,      1'b0, '0},
    '{32'd86400,      1'b0, '0},
    '{32'd31535999,   1'b0, '0},
    '{32'd31536000,   1'b0, '0},
    '{32'd68169600,   1'b0, '0},
    '{32'd94694399,   1'b0, '0},
    '{32'd946684799,  1'b0, '0},
    '{32'd946684800,  1'b0, '0},
    '{32'd951782400,  1'b0, '0},
    '{32'd951868800,  1'b0, '0},
    '{32'd1078099200, 1'b0, '0},
    '{32'd1551398399, 1'b0, '0},
    '{32'd2147483647, 1'b1, '{14'h2038, 5'h01, 6'h19, 6'h03, 7'h14, 7'h07, 1'b0}},
    '{32'd2147483648, 1'b0, '0},
    '{32'd4102444799, 1'b1, '{14'h2099, 5'h12, 6'h31, 6'h23, 7'h59, 7'h59, 1'b0}},
    '{32'd4102444800, 1'b1, PastRange},
    '{32'd4102444801, 1'b1, PastRange},
    '{32'h7FFFFFFF,   1'b0, '0},
    '{32'hFFFFFFFF,   1'b1, PastRange}
  };

  logic clk;
  logic rst_n;

  esbd_in_if  in_ch ();
  esbd_out_if out_ch ();

  epoch_seconds_to_bcd_date_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  pending_t    typed_q [$];
  date_t       date_q [$];
  int unsigned error_count;
  int unsigned sent_count;
  int unsigned checked_count;
  int unsigned past_range_count;
  int unsigned cycle_count;
  bit          idle_off;
  bit          hold_req;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("%0t: timeout, %0d results still expected", $time, date_q.size());
    $display("FAILED: results differ");
    $finish;
  end

  function automatic bit is_leap(int unsigned yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  function automatic int unsigned days_in_month(int unsigned yr, int unsigned mo);
    case (mo)
      2:          return is_leap(yr) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:    return 31;
    endcase
  endfunction

  function automatic logic [7:0] bcd8(int unsigned v);
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  function automatic date_t to_calendar(logic [31:0] secs);
    date_t       d;
    int unsigned rem;
    int unsigned yr;
    int unsigned mo;
    int unsigned len;
    d = '0;
    if (secs >= EpochEndSecs) begin
      d.out_of_range = 1'b1;
      return d;
    end
    rem = secs;
    yr  = 1970;
    len = is_leap(yr) ? 366 * 86400 : 365 * 86400;
    while (rem >= len) begin
      rem -= len;
      yr++;
      len = is_leap(yr) ? 366 * 86400 : 365 * 86400;
    end
    mo = 1;
    while (rem >= days_in_month(yr, mo) * 86400) begin
      rem -= days_in_month(yr, mo) * 86400;
      mo++;
    end
    d.year_bcd   = 14'({bcd8(yr / 100), bcd8(yr % 100)});
    d.month_bcd  = 5'(bcd8(mo));
    d.day_bcd    = 6'(bcd8(1 + rem / 86400));
    rem          = rem % 86400;
    d.hour_bcd   = 6'(bcd8(rem / 3600));
    rem          = rem % 3600;
    d.minute_bcd = 7'(bcd8(rem / 60));
    d.second_bcd = 7'(bcd8(rem % 60));
    return d;
  endfunction

  // Seconds near the first or last second of a random month, one off at times
  function automatic logic [31:0] near_month_edge();
    int unsigned yr;
    int unsigned mo;
    int unsigned base;
    logic [31:0] secs;
    yr   = $urandom_range(2099, 1970);
    mo   = $urandom_range(12, 1);
    base = 0;
    for (int unsigned y = 1970; y < yr; y++) base += is_leap(y) ? 366 * 86400 : 365 * 86400;
    for (int unsigned m = 1; m < mo; m++) base += days_in_month(yr, m) * 86400;
    if ($urandom_range(1, 0)) base += days_in_month(yr, mo) * 86400 - 1;
    secs = base;
    case ($urandom_range(3, 0))
      0:       secs = secs + 1;
      1:       secs = secs - 1;
      default: ;
    endcase
    return secs;
  endfunction

  function automatic logic [31:0] random_seconds();
    int unsigned pick;
    pick = $urandom_range(99, 0);
    if (pick < 15) return $urandom_range(32'hFFFFFFFF, EpochEndSecs);
    if (pick < 40) return near_month_edge();
    return $urandom_range(EpochEndSecs - 1, 0);
  endfunction

  function automatic int unsigned draw_wait();
    return idle_off ? 0 : $urandom_range(16, 0);
  endfunction

  task automatic send_seconds(logic [31:0] secs, logic fixed, date_t want);
    int unsigned gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    typed_q.push_back('{fixed, want});
    in_ch.valid               <= 1'b1;
    in_ch.seconds_since_epoch <= secs;
    do @(posedge clk); while (!in_ch.ready);
    sent_count++;
  endtask

  task automatic send_random(int unsigned count);
    repeat (count) send_seconds(random_seconds(), 1'b0, '0);
  endtask

  task automatic report_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // expectations are formed on the accepting edge of each input transaction
  always @(posedge clk) begin
    pending_t p;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      p = typed_q.pop_front();
      date_q.push_back(p.fixed ? p.want : to_calendar(in_ch.seconds_since_epoch));
    end
  end

  always @(posedge clk) begin
    date_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (date_q.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, year %0h month %0h day %0h", $time,
                 out_ch.year_bcd, out_ch.month_bcd, out_ch.day_bcd);
      end else begin
        want = date_q.pop_front();
        checked_count++;
        if (want.out_of_range) past_range_count++;
        report_field("year_bcd",     want.year_bcd,     out_ch.year_bcd);
        report_field("month_bcd",    want.month_bcd,    out_ch.month_bcd);
        report_field("day_bcd",      want.day_bcd,      out_ch.day_bcd);
        report_field("hour_bcd",     want.hour_bcd,     out_ch.hour_bcd);
        report_field("minute_bcd",   want.minute_bcd,   out_ch.minute_bcd);
        report_field("second_bcd",   want.second_bcd,   out_ch.second_bcd);
        report_field("out_of_range", want.out_of_range, out_ch.out_of_range);
      end
    end
  end

  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    wait (rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = HoldCycles;
      end else begin
        stall = draw_wait();
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin
    rst_n                     <= 1'b0;
    in_ch.valid               <= 1'b0;
    in_ch.seconds_since_epoch <= '0;
    idle_off = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DirectedRows[i]) send_seconds(DirectedRows[i].secs, DirectedRows[i].fixed,
                                           DirectedRows[i].want);
    in_ch.valid <= 1'b0;
    wait (date_q.size() == 0 && typed_q.size() == 0);

    idle_off = 1'b0;
    send_random(150);

    // output held off while the input keeps offering back to back
    idle_off = 1'b1;
    hold_req = 1'b1;
    send_random(30);
    in_ch.valid <= 1'b0;
    wait (date_q.size() == 0 && typed_q.size() == 0);

    idle_off = 1'b0;
    send_random(150);
    idle_off = 1'b1;
    send_random(100);
    in_ch.valid <= 1'b0;

    wait (date_q.size() == 0 && typed_q.size() == 0);
    repeat (DrainCycles) @(posedge clk);

    $display("Converted %0d epoch values (%0d past 2099): calendar edges, leap days,",
             checked_count, past_range_count);
    $display("random dates, idle gaps, a long output stall and a full drain.");
    if (error_count == 0 && sent_count == checked_count) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
